// ----- rtl/core/flf_pkg.sv -----
// flf_pkg: shared types, character codes and helpers for the text line folder
// used by flf_cell, flf_chain and text_line_folder_unit; no dependencies
package flf_pkg;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_SP     = 8'd32;
  localparam logic [7:0] CH_HYPHEN = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_NL
  } state_t;

  // per-cell control
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // chain control from the sequencer
  typedef struct packed {
    logic       shift;
    logic       wr_en;
    logic [7:0] wr_data;
    logic       wr1_en;
    logic [7:0] wr1_data;
  } chain_ctl_t;

  function automatic logic is_ws(input logic [7:0] ch);
    is_ws = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_NL);
  endfunction

endpackage

// ----- rtl/core/text_line_folder_unit.sv -----
// text_line_folder_unit: folds a byte stream into lines of at most LINE_LEN chars
// depends on flf_pkg and flf_chain (which uses flf_cell)
//
// usage:
//  - input channel: one transfer per byte; in_tuser high marks end of text,
//    in which case in_tdata is ignored and the stored line is flushed
//  - output channel: one transfer per emitted byte; out_tlast marks the final
//    byte caused by one input transfer
//  - an input that only stores a byte (or drops whitespace) leaves the unit idle
//  - an input that flushes a line of n stored bytes takes n + 1 output
//    transfers after it is accepted; bytes leave one per cycle from the
//    head of the cell chain unless out_tready stalls them; the chain
//    shifts down one place per emitted byte
//  - no new input is taken while a line is being flushed
//  - reset clears the fill count and line-start flags; store contents are
//    left as they are, only bytes below the fill count are ever emitted
//  - a stall on out_tready simply holds the output register and pauses the
//    chain shift, nothing is lost
module text_line_folder_unit #(
  parameter int LINE_LEN = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tuser,   // [0] end_of_text
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // last_of_run
);

  localparam int CW = $clog2(LINE_LEN + 1);
  localparam int IW = $clog2(LINE_LEN);

  flf_pkg::state_t state_r, state_nxt;

  // line state
  logic [CW-1:0] fill_r, fill_nxt;
  logic          started_r, started_nxt;
  logic          pend_r, pend_nxt;

  // flush bookkeeping
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          sub_use_r, sub_use_nxt;
  logic [7:0]    sub_char_r, sub_char_nxt;
  logic [1:0]    post_fill_r, post_fill_nxt;
  logic [7:0]    post_b0_r, post_b0_nxt;
  logic [7:0]    post_b1_r, post_b1_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  flf_pkg::chain_ctl_t chain_ctl;
  logic [IW-1:0]       wr_idx;
  logic [7:0]          head, last_b, last2_b;
  logic                slot_free;
  logic                full;

  flf_chain #(
    .LINE_LEN (LINE_LEN)
  ) u_chain (
    .clk    (clk),
    .ctl    (chain_ctl),
    .wr_idx (wr_idx),
    .head   (head),
    .last   (last_b),
    .last2  (last2_b)
  );

  assign slot_free = !out_valid_r || out_tready;
  assign full      = (fill_r >= CW'(LINE_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flf_pkg::ST_IDLE;
      fill_r      <= '0;
      started_r   <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      started_r   <= started_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sub_use_r   <= sub_use_nxt;
    sub_char_r  <= sub_char_nxt;
    post_fill_r <= post_fill_nxt;
    post_b0_r   <= post_b0_nxt;
    post_b1_r   <= post_b1_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    started_nxt   = started_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    sub_use_nxt   = sub_use_r;
    sub_char_nxt  = sub_char_r;
    post_fill_nxt = post_fill_r;
    post_b0_nxt   = post_b0_r;
    post_b1_nxt   = post_b1_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    chain_ctl     = '0;
    wr_idx        = fill_r[IW-1:0];

    unique case (state_r)
      flf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          priority if (in_tuser) begin
            // end of text: flush whatever is stored, then back to reset state
            cnt_nxt       = fill_r;
            fill_nxt      = '0;
            started_nxt   = 1'b0;
            pend_nxt      = 1'b0;
            sub_use_nxt   = 1'b0;
            post_fill_nxt = 2'd0;
            state_nxt     = (fill_r == '0) ? flf_pkg::ST_NL : flf_pkg::ST_DRAIN;
          end else if (!started_r) begin
            // line start: whitespace dropped, repeated newlines become blank lines
            priority if (in_tdata == flf_pkg::CH_NL && pend_r) begin
              cnt_nxt       = '0;
              sub_use_nxt   = 1'b0;
              post_fill_nxt = 2'd0;
              state_nxt     = flf_pkg::ST_NL;
            end else if (in_tdata == flf_pkg::CH_NL) begin
              pend_nxt = 1'b1;
            end else if (!flf_pkg::is_ws(in_tdata)) begin
              chain_ctl.wr_en   = 1'b1;
              chain_ctl.wr_data = in_tdata;
              fill_nxt          = fill_r + CW'(1);
              started_nxt       = 1'b1;
              pend_nxt          = 1'b0;
            end else begin
              // leading space or tab
            end
          end else if (in_tdata == flf_pkg::CH_NL) begin
            // newline ends the line
            cnt_nxt       = fill_r;
            fill_nxt      = '0;
            started_nxt   = 1'b0;
            pend_nxt      = 1'b1;
            sub_use_nxt   = 1'b0;
            post_fill_nxt = 2'd0;
            state_nxt     = (fill_r == '0) ? flf_pkg::ST_NL : flf_pkg::ST_DRAIN;
          end else if (full) begin
            // full line: flush it, the carried bytes are loaded after the newline
            cnt_nxt     = CW'(LINE_LEN);
            sub_use_nxt = 1'b0;
            state_nxt   = flf_pkg::ST_DRAIN;
            priority if (flf_pkg::is_ws(in_tdata)) begin
              fill_nxt      = '0;
              started_nxt   = 1'b0;
              pend_nxt      = 1'b0;
              post_fill_nxt = 2'd0;
            end else if (flf_pkg::is_ws(last_b)) begin
              fill_nxt      = CW'(1);
              post_fill_nxt = 2'd1;
              post_b0_nxt   = in_tdata;
            end else begin
              // word continues: hyphenate, or blank if a single char follows a space
              sub_use_nxt   = 1'b1;
              sub_char_nxt  = flf_pkg::is_ws(last2_b) ? flf_pkg::CH_SP
                                                      : flf_pkg::CH_HYPHEN;
              fill_nxt      = CW'(2);
              post_fill_nxt = 2'd2;
              post_b0_nxt   = last_b;
              post_b1_nxt   = in_tdata;
            end
          end else begin
            chain_ctl.wr_en   = 1'b1;
            chain_ctl.wr_data = in_tdata;
            fill_nxt          = fill_r + CW'(1);
          end
        end
      end

      flf_pkg::ST_DRAIN: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_data_nxt    = (cnt_r == CW'(1) && sub_use_r) ? sub_char_r : head;
          out_last_nxt    = 1'b0;
          chain_ctl.shift = 1'b1;
          cnt_nxt         = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = flf_pkg::ST_NL;
          end
        end
      end

      flf_pkg::ST_NL: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt       = flf_pkg::CH_NL;
          out_last_nxt       = 1'b1;
          wr_idx             = '0;
          chain_ctl.wr_en    = (post_fill_r != 2'd0);
          chain_ctl.wr_data  = post_b0_r;
          chain_ctl.wr1_en   = (post_fill_r == 2'd2);
          chain_ctl.wr1_data = post_b1_r;
          state_nxt          = flf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = flf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // fill count never passes the line length
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(LINE_LEN))
    else $error("fill count above line length");

  // a started line never has a pending newline
  a_start_pend: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> !pend_r)
    else $error("started line with pending newline");

  // idle with a started line means at least one stored byte
  a_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == flf_pkg::ST_IDLE && started_r) |-> fill_r != '0)
    else $error("started line with empty store");

  // draining always has bytes left to send
  a_drain_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == flf_pkg::ST_DRAIN) |-> cnt_r != '0)
    else $error("drain with zero count");

endmodule

// ----- rtl/core/flf_cell.sv -----
// flf_cell: one byte of the line store, loads a byte or takes its neighbor's
// depends on flf_pkg
module flf_cell (
  input  logic               clk,
  input  flf_pkg::cell_ctl_t ctl,
  input  logic [7:0]         load_data,
  input  logic [7:0]         nbr_data,
  output logic [7:0]         data
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- rtl/core/flf_chain.sv -----
// flf_chain: row of flf_cell forming the line store, shifts toward cell 0
// depends on flf_pkg and flf_cell
module flf_chain #(
  parameter int LINE_LEN = 40
) (
  input  logic                        clk,
  input  flf_pkg::chain_ctl_t         ctl,
  input  logic [$clog2(LINE_LEN)-1:0] wr_idx,
  output logic [7:0]                  head,
  output logic [7:0]                  last,
  output logic [7:0]                  last2
);

  localparam int IW = $clog2(LINE_LEN);

  logic [7:0] cell_q [LINE_LEN];

  for (genvar i = 0; i < LINE_LEN; i++) begin : g_cell
    flf_pkg::cell_ctl_t cctl;
    logic [7:0]         ld_data;
    logic [7:0]         nbr;

    always_comb begin
      cctl.shift = ctl.shift;
      cctl.load  = 1'b0;
      ld_data    = ctl.wr_data;
      if (ctl.wr_en && (wr_idx == IW'(i))) begin
        cctl.load = 1'b1;
      end else if (ctl.wr1_en && (i == 1)) begin
        cctl.load = 1'b1;
        ld_data   = ctl.wr1_data;
      end
    end

    // top cell has no upper neighbor, keeps its byte on a shift
    if (i == LINE_LEN - 1) begin : g_top
      assign nbr = cell_q[i];
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    flf_cell u_cell (
      .clk       (clk),
      .ctl       (cctl),
      .load_data (ld_data),
      .nbr_data  (nbr),
      .data      (cell_q[i])
    );
  end

  assign head  = cell_q[0];
  assign last  = cell_q[LINE_LEN-1];
  assign last2 = cell_q[LINE_LEN-2];

endmodule
